// ===== hdl/octree_leaf_path_nibble_packer_assert.svh =====
// Assertion macros used by the datapath of the octree leaf path nibble packer RTL.
`ifndef OCTREE_LEAF_PATH_NIBBLE_PACKER_ASSERT_SVH
`define OCTREE_LEAF_PATH_NIBBLE_PACKER_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is high.
`define OLNP_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("olnp assertion failed");
// Next-cycle implication, disabled while reset is high.
`define OLNP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("olnp assertion failed");
`else
`define OLNP_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define OLNP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== hdl/olnp_pkg.sv =====
// Shared types, constants and helper functions of the leaf path nibble packer.
package olnp_pkg;

   localparam int DEPTH_W = 5;
   localparam int OCC_W   = 8;
   localparam int POS_W   = 4;
   localparam int CODE_W  = 4;
   localparam int IDX_W   = 3;
   localparam int BYTE_W  = 2 * CODE_W;

   // operation codes of an input word
   localparam logic OP_NODE  = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SINGLE,
      ST_LEAF
   } state_type;

   // what an accepted word turns into
   typedef enum logic [1:0] {
      OUT_NONE,
      OUT_SINGLE,
      OUT_LEAF
   } outcome_type;

   typedef struct packed {
      logic accept;
      logic emit_single;
      logic emit_leaf;
   } cmd_type;

   typedef struct packed {
      outcome_type outcome;
      logic        leaf_final;
      logic        out_free;
   } status_type;

   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] index;
   } pick_type;

   // Position of the n-th set bit of an occupancy byte, lowest bit first.
   function automatic pick_type nth_set_bit(input logic [OCC_W-1:0] occ,
                                            input logic [POS_W-1:0] n);
      pick_type         pick;
      logic [POS_W-1:0] seen;
      pick = '0;
      seen = '0;
      for (int i = 0; i < OCC_W; i++) begin
         if (occ[i]) begin
            if (!pick.found && seen == n) begin
               pick.found = 1'b1;
               pick.index = IDX_W'(i);
            end
            seen = seen + POS_W'(1);
         end
      end
      return pick;
   endfunction

   // Index of the lowest set bit; zero when the byte is empty.
   function automatic logic [IDX_W-1:0] lowest_bit(input logic [OCC_W-1:0] occ);
      logic [IDX_W-1:0] idx;
      idx = '0;
      for (int i = OCC_W - 1; i >= 0; i--) begin
         if (occ[i]) begin
            idx = IDX_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

// ===== hdl/olnp_ctrl.sv =====
// Controller state machine: accepts words and sequences result bytes.
module olnp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  olnp_pkg::status_type status,
   output olnp_pkg::cmd_type    cmd
);
   import olnp_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // no word is taken while reset is high
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.accept = 1'b1;
               case (status.outcome)
                  OUT_SINGLE: state_in = ST_SINGLE;
                  OUT_LEAF:   state_in = ST_LEAF;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_SINGLE: begin
            if (status.out_free) begin
               cmd.emit_single = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_LEAF: begin
            if (status.out_free) begin
               cmd.emit_leaf = 1'b1;
               if (status.leaf_final) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hdl/olnp_datapath.sv =====
// Datapath: tree state, leaf code sequencing, nibble packing and output word.
`include "octree_leaf_path_nibble_packer_assert.svh"

module olnp_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  olnp_pkg::cmd_type                   cmd,
   output olnp_pkg::status_type                status,
   input  logic                                req_operation,
   input  logic [olnp_pkg::DEPTH_W-1:0]        req_node_depth,
   input  logic [olnp_pkg::OCC_W-1:0]          req_occupancy,
   input  logic                                csr_wr_en,
   input  logic [olnp_pkg::DEPTH_W-1:0]        csr_wr_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [olnp_pkg::BYTE_W-1:0]         rsp_packed_byte,
   output logic                                rsp_last,
   output logic                                rsp_order_error
);
   import olnp_pkg::*;

   // tree state
   logic [DEPTH_W-1:0] base_depth_ff;
   logic [OCC_W-1:0]   base_occ_ff, base_occ_in;
   logic [POS_W-1:0]   base_pos_ff, base_pos_in;
   logic [OCC_W-1:0]   mid_occ_ff, mid_occ_in;
   logic [POS_W-1:0]   mid_pos_ff, mid_pos_in;
   logic [CODE_W-1:0]  first_code_ff, first_code_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [CODE_W-1:0]  pend_nib_ff, pend_nib_in;

   // work registers of the current word
   logic [OCC_W-1:0]   rem_mask_ff, rem_mask_in;
   logic [1:0]         phase_ff, phase_in;
   logic [CODE_W-1:0]  second_ff, second_in;
   logic [CODE_W-1:0]  single_nib_ff, single_nib_in;
   logic               single_err_ff, single_err_in;

   // output word
   logic               rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]  rsp_byte_ff, rsp_byte_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_err_ff, rsp_err_in;

   logic [DEPTH_W:0]   depth_ext, base_ext;
   logic               is_base, is_mid, is_leaf;
   pick_type           base_pick, mid_pick;
   outcome_type        outcome;

   logic [IDX_W-1:0]   low_idx;
   logic [CODE_W-1:0]  leaf_code;
   logic [OCC_W-1:0]   rest_mask;
   logic               more;
   logic [BYTE_W-1:0]  step_byte;
   logic               step_last;

   // depth classification against the base depth
   always_comb begin
      depth_ext = {1'b0, req_node_depth};
      base_ext  = {1'b0, base_depth_ff};
      is_base   = (depth_ext == base_ext);
      is_mid    = (depth_ext == base_ext + (DEPTH_W+1)'(1));
      is_leaf   = (depth_ext == base_ext + (DEPTH_W+1)'(2));
      base_pick = nth_set_bit(base_occ_ff, base_pos_ff);
      mid_pick  = nth_set_bit(mid_occ_ff, mid_pos_ff);
   end

   // what the offered word will produce
   always_comb begin
      outcome = OUT_NONE;
      if (req_operation == OP_FLUSH) begin
         outcome = pend_valid_ff ? OUT_SINGLE : OUT_NONE;
      end else if (is_mid) begin
         outcome = base_pick.found ? OUT_NONE : OUT_SINGLE;
      end else if (is_leaf) begin
         if (!mid_pick.found) begin
            outcome = OUT_SINGLE;
         end else if (req_occupancy != '0) begin
            outcome = OUT_LEAF;
         end
      end
   end

   // one leaf step: two codes of the stream per byte
   always_comb begin
      low_idx   = lowest_bit(rem_mask_ff);
      leaf_code = CODE_W'({1'b0, low_idx}) + CODE_W'(1);
      rest_mask = rem_mask_ff & (rem_mask_ff - OCC_W'(1));
      more      = (rest_mask != '0);
      step_byte = '0;
      step_last = 1'b0;
      if (pend_valid_ff) begin
         step_byte = {first_code_ff, pend_nib_ff};
      end else begin
         case (phase_ff)
            2'd0: begin
               step_byte = {second_ff, first_code_ff};
               step_last = !more;
            end
            2'd1: begin
               step_byte = {leaf_code, second_ff};
               step_last = !more;
            end
            default: begin
               step_byte = {first_code_ff, leaf_code};
            end
         endcase
      end
   end

   always_comb begin
      status.outcome    = outcome;
      status.leaf_final = step_last;
      status.out_free   = !rsp_valid_ff || rsp_ready;
   end

   // next values of state, work and output registers
   always_comb begin
      base_occ_in   = base_occ_ff;
      base_pos_in   = base_pos_ff;
      mid_occ_in    = mid_occ_ff;
      mid_pos_in    = mid_pos_ff;
      first_code_in = first_code_ff;
      pend_valid_in = pend_valid_ff;
      pend_nib_in   = pend_nib_ff;
      rem_mask_in   = rem_mask_ff;
      phase_in      = phase_ff;
      second_in     = second_ff;
      single_nib_in = single_nib_ff;
      single_err_in = single_err_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_err_in    = rsp_err_ff;

      if (cmd.accept) begin
         single_nib_in = '0;
         single_err_in = 1'b1;
         if (req_operation == OP_FLUSH) begin
            // flush: hand out the odd code padded with zero
            if (pend_valid_ff) begin
               single_nib_in = pend_nib_ff;
               single_err_in = 1'b0;
               pend_valid_in = 1'b0;
               pend_nib_in   = '0;
            end
         end else if (is_base) begin
            base_occ_in = req_occupancy;
            base_pos_in = '0;
         end else if (is_mid) begin
            mid_occ_in = req_occupancy;
            mid_pos_in = '0;
            if (base_pick.found) begin
               first_code_in = CODE_W'({1'b0, base_pick.index}) + CODE_W'(1);
               base_pos_in   = base_pos_ff + POS_W'(1);
            end else begin
               first_code_in = '0;
            end
         end else if (is_leaf && mid_pick.found) begin
            second_in   = CODE_W'({1'b0, mid_pick.index}) + CODE_W'(1);
            mid_pos_in  = mid_pos_ff + POS_W'(1);
            rem_mask_in = req_occupancy;
            phase_in    = 2'd0;
         end
      end

      if (cmd.emit_single) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = {{CODE_W{1'b0}}, single_nib_ff};
         rsp_last_in  = 1'b1;
         rsp_err_in   = single_err_ff;
      end

      if (cmd.emit_leaf) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = step_byte;
         rsp_last_in  = step_last;
         rsp_err_in   = 1'b0;
         if (pend_valid_ff) begin
            pend_valid_in = 1'b0;
            pend_nib_in   = '0;
            phase_in      = 2'd1;
         end else begin
            case (phase_ff)
               2'd0: begin
                  phase_in = 2'd2;
                  if (!more) begin
                     // last leaf code of the word waits for a partner
                     pend_valid_in = 1'b1;
                     pend_nib_in   = leaf_code;
                  end
               end
               2'd1: begin
                  rem_mask_in = rest_mask;
                  phase_in    = 2'd0;
               end
               default: begin
                  rem_mask_in = rest_mask;
                  phase_in    = 2'd1;
               end
            endcase
         end
      end
   end

   // control and tree state
   always_ff @(posedge clock) begin
      if (reset) begin
         base_depth_ff <= '0;
         base_occ_ff   <= '0;
         base_pos_ff   <= '0;
         mid_occ_ff    <= '0;
         mid_pos_ff    <= '0;
         first_code_ff <= '0;
         pend_valid_ff <= 1'b0;
         pend_nib_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            base_depth_ff <= csr_wr_data;
         end
         base_occ_ff   <= base_occ_in;
         base_pos_ff   <= base_pos_in;
         mid_occ_ff    <= mid_occ_in;
         mid_pos_ff    <= mid_pos_in;
         first_code_ff <= first_code_in;
         pend_valid_ff <= pend_valid_in;
         pend_nib_ff   <= pend_nib_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rem_mask_ff   <= rem_mask_in;
      phase_ff      <= phase_in;
      second_ff     <= second_in;
      single_nib_ff <= single_nib_in;
      single_err_ff <= single_err_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_err_ff    <= rsp_err_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_packed_byte = rsp_byte_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_order_error = rsp_err_ff;

   `OLNP_ASSERT_IMPLIES(a_err_is_last, clock, reset, rsp_valid_ff && rsp_err_ff, rsp_last_ff)
   `OLNP_ASSERT_IMPLIES(a_err_byte_zero, clock, reset, rsp_valid_ff && rsp_err_ff, rsp_byte_ff == '0)
   `OLNP_ASSERT_IMPLIES(a_leaf_has_bits, clock, reset, cmd.emit_leaf, rem_mask_ff != '0)
   `OLNP_ASSERT_IMPLIES(a_pend_at_start, clock, reset, cmd.emit_leaf && pend_valid_ff, phase_ff == 2'd0)
   `OLNP_ASSERT_NEXT(a_emit_fills_out, clock, reset, cmd.emit_single || cmd.emit_leaf, rsp_valid_ff)

endmodule

// ===== hdl/octree_leaf_path_nibble_packer.sv =====
// Top level of the octree leaf path nibble packer: controller plus datapath.
//
// Node words are taken one at a time. A flush or a node that only stores
// occupancy is done in the cycle it is accepted; a flush with a pending code
// or an order error moves to the single state, which loads one byte into the
// output register once it is free. A node two levels below the base depth
// with n occupied leaf slots gives 3n codes, and the output register sends
// them two to a byte, one byte per cycle while the consumer does not stall;
// such a node holds the input until its last byte is loaded. The next word
// is accepted as soon as that last byte is in the output register, even while it waits.
module octree_leaf_path_nibble_packer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [olnp_pkg::DEPTH_W-1:0]  csr_wr_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_operation,
   input  logic [olnp_pkg::DEPTH_W-1:0]  req_node_depth,
   input  logic [olnp_pkg::OCC_W-1:0]    req_occupancy,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [olnp_pkg::BYTE_W-1:0]   rsp_packed_byte,
   output logic                          rsp_last,
   output logic                          rsp_order_error
);
   import olnp_pkg::*;

   cmd_type    cmd;
   status_type status;

   olnp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   olnp_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_operation   (req_operation),
      .req_node_depth  (req_node_depth),
      .req_occupancy   (req_occupancy),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_packed_byte (rsp_packed_byte),
      .rsp_last        (rsp_last),
      .rsp_order_error (rsp_order_error)
   );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the octree leaf path nibble packer.

// Scoreboard: tracks the packer's tree state and the bytes it still owes.
class leaf_path_board;
   typedef struct packed {
      logic [7:0] packed_byte;
      logic       last;
      logic       order_error;
   } leaf_byte_type;

   leaf_byte_type owed_bytes[$];
   int            errors;
   logic [4:0]    base_depth;
   logic [7:0]    base_occ;
   logic [7:0]    mid_occ;
   logic [3:0]    base_pos;
   logic [3:0]    mid_pos;
   logic [3:0]    first_code;
   logic [3:0]    pend_nib;
   logic          pend_valid;

   function new();
      errors     = 0;
      base_depth = '0;
      base_occ   = '0;
      mid_occ    = '0;
      base_pos   = '0;
      mid_pos    = '0;
      first_code = '0;
      pend_nib   = '0;
      pend_valid = 1'b0;
   endfunction

   function void set_base(input logic [4:0] depth);
      base_depth = depth;
   endfunction

   // child slot of the n-th set bit, -1 once the list is used up
   function int nth_child(input logic [7:0] occ, input logic [3:0] n);
      int seen;
      seen = 0;
      for (int i = 0; i < 8; i++) begin
         if (occ[i]) begin
            if (seen == int'(n)) return i;
            seen++;
         end
      end
      return -1;
   endfunction

   function void owe(input logic [7:0] b, input logic l, input logic e);
      leaf_byte_type w;
      w.packed_byte = b;
      w.last        = l;
      w.order_error = e;
      owed_bytes.insert(owed_bytes.size(), w);
   endfunction

   // one code into the nibble stream; 1 when it completes a byte
   function int push_code(input logic [3:0] code);
      if (pend_valid) begin
         owe({code, pend_nib}, 1'b0, 1'b0);
         pend_valid = 1'b0;
         pend_nib   = '0;
         return 1;
      end
      pend_nib   = code;
      pend_valid = 1'b1;
      return 0;
   endfunction

   // predict the bytes caused by one accepted word
   function void note_word(input logic op, input logic [4:0] depth, input logic [7:0] occ);
      int            child;
      int            made;
      logic [3:0]    mid_code;
      leaf_byte_type tail;
      if (op == olnp_pkg::OP_FLUSH) begin
         if (pend_valid) begin
            owe({4'h0, pend_nib}, 1'b1, 1'b0);
            pend_valid = 1'b0;
            pend_nib   = '0;
         end
         return;
      end
      if (int'(depth) == int'(base_depth)) begin
         base_occ = occ;
         base_pos = '0;
      end else if (int'(depth) == int'(base_depth) + 1) begin
         child   = nth_child(base_occ, base_pos);
         mid_occ = occ;
         mid_pos = '0;
         if (child < 0) begin
            first_code = '0;
            owe(8'h00, 1'b1, 1'b1);
         end else begin
            first_code = 4'(child + 1);
            base_pos   = base_pos + 4'd1;
         end
      end else if (int'(depth) == int'(base_depth) + 2) begin
         child = nth_child(mid_occ, mid_pos);
         if (child < 0) begin
            owe(8'h00, 1'b1, 1'b1);
         end else begin
            mid_code = 4'(child + 1);
            mid_pos  = mid_pos + 4'd1;
            made     = 0;
            for (int i = 0; i < 8; i++) begin
               if (occ[i]) begin
                  made += push_code(first_code);
                  made += push_code(mid_code);
                  made += push_code(4'(i + 1));
               end
            end
            // flag the final byte of this node
            if (made > 0) begin
               tail      = owed_bytes[owed_bytes.size() - 1];
               tail.last = 1'b1;
               owed_bytes[owed_bytes.size() - 1] = tail;
            end
         end
      end
   endfunction

   function void check_byte(input logic [7:0] b, input logic l, input logic e);
      leaf_byte_type want;
      if (owed_bytes.size() == 0) begin
         $display("%0t: unexpected word byte %02h last %0d error %0d", $time, b, l, e);
         errors++;
         return;
      end
      want = owed_bytes.pop_front();
      if (b !== want.packed_byte) begin
         $display("%0t: packed_byte expected %02h got %02h", $time, want.packed_byte, b);
         errors++;
      end
      if (l !== want.last) begin
         $display("%0t: last expected %0d got %0d", $time, want.last, l);
         errors++;
      end
      if (e !== want.order_error) begin
         $display("%0t: order_error expected %0d got %0d", $time, want.order_error, e);
         errors++;
      end
   endfunction
endclass

module testbench;
   import olnp_pkg::*;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_wr_en = 1'b0;
   logic [DEPTH_W-1:0]  csr_wr_data = '0;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_operation = OP_NODE;
   logic [DEPTH_W-1:0]  req_node_depth = '0;
   logic [OCC_W-1:0]    req_occupancy = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [BYTE_W-1:0]   rsp_packed_byte;
   logic                rsp_last;
   logic                rsp_order_error;

   leaf_path_board board = new();
   int             words_sent = 0;
   logic           calm = 1'b0;
   logic           hold_request = 1'b0;

   octree_leaf_path_nibble_packer u_top (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_node_depth  (req_node_depth),
      .req_occupancy   (req_occupancy),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_packed_byte (rsp_packed_byte),
      .rsp_last        (rsp_last),
      .rsp_order_error (rsp_order_error)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // hard stop in case the packer hangs
   initial begin
      #6000000;
      $display("Regression FAIL");
      $finish;
   end

   // offer one word, optionally after a gap; valid stays high once accepted
   task automatic send_word(input logic op, input logic [4:0] depth, input logic [7:0] occ);
      while (!calm && $urandom_range(0, 99) < 16) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_node_depth <= depth;
      req_occupancy  <= occ;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_word(op, depth, occ);
      words_sent++;
   endtask

   // stop offering and wait until every owed byte is back
   task automatic settle();
      req_valid <= 1'b0;
      while (board.owed_bytes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_base(input logic [4:0] depth);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= depth;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.set_base(depth);
   endtask

   // mostly sparse occupancies to keep trees short
   function automatic logic [7:0] pick_occ();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'hFF;
         2, 3, 4: return 8'h01 << $urandom_range(0, 7);
         5, 6: return (8'h01 << $urandom_range(0, 7)) | (8'h01 << $urandom_range(0, 7));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [7:0] pick_leaf_occ();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1, 2: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // stray flushes and off-tree words between the well-formed ones
   task automatic maybe_noise();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
         send_word(OP_FLUSH, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)));
      end else if (roll < 8) begin
         send_word(OP_NODE, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)));
      end
   endtask

   // one depth-first subtree: base node, its middle nodes, their leaf nodes
   task automatic send_tree(input int base);
      logic [7:0] top_occ;
      logic [7:0] mid_occ;
      int         mids;
      int         leaves;
      top_occ = pick_occ();
      mids    = $countones(top_occ) + (($urandom_range(0, 9) == 0) ? 1 : 0);
      maybe_noise();
      send_word(OP_NODE, 5'(base), top_occ);
      for (int m = 0; m < mids; m++) begin
         mid_occ = pick_occ();
         leaves  = $countones(mid_occ) + (($urandom_range(0, 9) == 0) ? 1 : 0);
         maybe_noise();
         send_word(OP_NODE, 5'(base + 1), mid_occ);
         for (int f = 0; f < leaves; f++) begin
            maybe_noise();
            send_word(OP_NODE, 5'(base + 2), pick_leaf_occ());
         end
      end
      if ($urandom_range(0, 2) == 0) begin
         send_word(OP_FLUSH, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)));
      end
   endtask

   // result side: check every accepted byte, random and long stalls
   initial begin
      int   stall_left;
      logic hold_seen;
      stall_left = 0;
      hold_seen  = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            board.check_byte(rsp_packed_byte, rsp_last, rsp_order_error);
         end
         if (hold_request && !hold_seen) begin
            hold_seen  = 1'b1;
            stall_left = 300;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm || ($urandom_range(0, 99) >= 16);
         end
      end
   end

   // stimulus
   initial begin
      int phase_base[5];
      int stop_at;
      phase_base[0] = 28;
      phase_base[1] = $urandom_range(1, 26);
      phase_base[2] = 0;
      phase_base[3] = 27;
      phase_base[4] = $urandom_range(1, 26);

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_base(5'd0);

      // directed: base depth 0
      send_word(OP_FLUSH, 5'd31, 8'hFF);  // nothing pending
      send_word(OP_NODE, 5'd31, 8'hAA);   // off-tree depth, ignored
      send_word(OP_NODE, 5'd0, 8'hFF);
      send_word(OP_NODE, 5'd1, 8'h81);
      send_word(OP_NODE, 5'd2, 8'hFF);    // full leaf: twelve bytes
      send_word(OP_NODE, 5'd2, 8'h00);    // empty leaf uses up a middle child
      send_word(OP_NODE, 5'd2, 8'h01);    // past the middle children
      send_word(OP_NODE, 5'd1, 8'h02);
      send_word(OP_NODE, 5'd2, 8'h01);    // odd code count leaves one pending
      send_word(OP_FLUSH, 5'd0, 8'h00);   // pad with zero
      send_word(OP_FLUSH, 5'd0, 8'h00);
      send_word(OP_NODE, 5'd0, 8'h00);
      send_word(OP_NODE, 5'd1, 8'h10);    // empty base node: order error
      send_word(OP_NODE, 5'd2, 8'h80);    // codes with a zero base code
      send_word(OP_NODE, 5'd2, 8'h01);
      send_word(OP_FLUSH, 5'd17, 8'h55);
      send_word(OP_NODE, 5'd0, 8'h01);
      send_word(OP_NODE, 5'd1, 8'h00);
      send_word(OP_NODE, 5'd1, 8'hFF);    // past the single base child
      send_word(OP_NODE, 5'd2, 8'h01);
      send_word(OP_FLUSH, 5'd31, 8'hFF);
      settle();

      // random phases over several base depths
      for (int p = 0; p < 5; p++) begin
         write_base(5'(phase_base[p]));
         calm = (p == 2);
         if (p == 1) hold_request = 1'b1;
         stop_at = words_sent + 68;
         while (words_sent < stop_at) send_tree(phase_base[p]);
         settle();
      end
      calm = 1'b0;

      if (board.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/olnp_pkg.sv
hdl/olnp_ctrl.sv
hdl/olnp_datapath.sv
hdl/octree_leaf_path_nibble_packer.sv
tb/testbench.sv
